### rtl/pstk_pkg.sv
// pstk_pkg: shared types and constants for the priority sorted keyed table
// holds the command/result transaction structs, table entry, sequencer states
// no dependencies
package pstk_pkg;

	localparam int CAPACITY     = 8;
	localparam int IDX_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int KEY_W        = 64;
	localparam int PRIO_W       = 7;
	localparam int STATUS_W     = 3;
	localparam int RANK_W       = 3;
	localparam int COUNT_W      = 4;

	localparam logic [PRIO_W-1:0] MAX_PRIORITY = PRIO_W'(100);
	localparam logic [PRIO_W-1:0] ZERO_PRIORITY = '0;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} pstk_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK           = 3'd0,
		STAT_NOT_FOUND    = 3'd1,
		STAT_FULL         = 3'd2,
		STAT_BAD_PRIORITY = 3'd3,
		STAT_DUPLICATE    = 3'd4
	} pstk_status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] priority_req;
	} pstk_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PRIO_W-1:0]   found_priority;
		logic [RANK_W-1:0]   rank;
		logic [COUNT_W-1:0]  count;
	} pstk_result_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} pstk_entry_t;

	localparam int ENTRY_W = $bits(pstk_entry_t);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		pstk_entry_t      wdata;
		logic [IDX_W-1:0] raddr;
	} pstk_ram_req_t;

	typedef struct packed {
		logic         done;
		pstk_result_t res;
	} pstk_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_APPEND,
		ST_EX_LOAD_RD,
		ST_EX_LOAD,
		ST_EX_J_RD,
		ST_EX_J_CMP,
		ST_EX_WB,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} pstk_state_t;

endpackage

### rtl/pstk_ram.sv
// pstk_ram: generic single write port, single read port ram, registered read
// standalone, no package dependency
module pstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/pstk_ctrl.sv
// pstk_ctrl: sequencer for lookup, append, exchange pass and delete shift
// drives the entry ram through one shared key/priority compare unit
// depends on pstk_pkg
module pstk_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  pstk_pkg::pstk_cmd_t     cmd,
	output pstk_pkg::pstk_ram_req_t ram_req,
	input  pstk_pkg::pstk_entry_t   rd_entry,
	output pstk_pkg::pstk_rsp_t     rsp
);
	import pstk_pkg::*;

	pstk_state_t          state_q, state_d;
	logic [1:0]           op_q;
	logic [KEY_W-1:0]     key_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     jdx_q;
	logic [CNT_W-1:0]     count_q;
	pstk_entry_t          cur_q;
	logic [STATUS_W-1:0]  status_q;
	logic [PRIO_W-1:0]    fprio_q;
	logic [RANK_W-1:0]    rank_q;

	logic                 accept;
	logic                 key_hit;
	logic                 prio_lt;
	logic                 bad_prio;
	logic                 full;
	logic [CNT_W-1:0]     idx_inc;
	logic [CNT_W-1:0]     jdx_inc;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);

	// shared compare unit
	assign key_hit  = (rd_entry.key == key_q);
	assign prio_lt  = (cur_q.prio < rd_entry.prio);

	assign bad_prio = (cmd.priority_req == ZERO_PRIORITY) || (cmd.priority_req > MAX_PRIORITY);
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign idx_inc  = idx_q + CNT_W'(1);
	assign jdx_inc  = jdx_q + CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.opcode)
						OP_ADD:    state_d = (full || bad_prio) ? ST_DONE : ST_SCAN_RD;
						OP_FIND:   state_d = ST_SCAN_RD;
						OP_DELETE: state_d = ST_SCAN_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN_RD: begin
				if (idx_q >= count_q) begin
					state_d = (op_q == OP_ADD) ? ST_APPEND : ST_DONE;
				end else begin
					state_d = ST_SCAN_CMP;
				end
			end
			ST_SCAN_CMP: begin
				if (key_hit) begin
					state_d = (op_q == OP_DELETE) ? ST_SH_RD : ST_DONE;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_APPEND:     state_d = ST_EX_LOAD_RD;
			ST_EX_LOAD_RD: state_d = (idx_inc >= count_q) ? ST_DONE : ST_EX_LOAD;
			ST_EX_LOAD:    state_d = ST_EX_J_RD;
			ST_EX_J_RD:    state_d = ST_EX_J_CMP;
			ST_EX_J_CMP:   state_d = (jdx_inc < count_q) ? ST_EX_J_RD : ST_EX_WB;
			ST_EX_WB:      state_d = ST_EX_LOAD_RD;
			ST_SH_RD:      state_d = (idx_inc >= count_q) ? ST_DONE : ST_SH_WR;
			ST_SH_WR:      state_d = ST_SH_RD;
			ST_DONE:       state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// ram control and response
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = cur_q;
		rsp.done               = 1'b0;
		rsp.res.status         = status_q;
		rsp.res.found_priority = fprio_q;
		rsp.res.rank           = rank_q;
		rsp.res.count          = COUNT_W'(count_q);
		case (state_q)
			ST_SCAN_RD:    ram_req.raddr = idx_q[IDX_W-1:0];
			ST_EX_LOAD_RD: ram_req.raddr = idx_q[IDX_W-1:0];
			ST_EX_J_RD:    ram_req.raddr = jdx_q[IDX_W-1:0];
			ST_SH_RD:      ram_req.raddr = idx_inc[IDX_W-1:0];
			ST_APPEND: begin
				ram_req.we         = 1'b1;
				ram_req.waddr      = count_q[IDX_W-1:0];
				ram_req.wdata.key  = key_q;
				ram_req.wdata.prio = prio_q;
			end
			ST_EX_J_CMP: begin
				ram_req.we    = prio_lt;
				ram_req.waddr = jdx_q[IDX_W-1:0];
			end
			ST_EX_WB: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q[IDX_W-1:0];
			end
			ST_SH_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q[IDX_W-1:0];
				ram_req.wdata = rd_entry;
			end
			ST_DONE:  rsp.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_APPEND) begin
				count_q <= count_q + CNT_W'(1);
			end else if (state_q == ST_SH_RD && idx_inc >= count_q) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= cmd.opcode;
					key_q    <= cmd.key;
					prio_q   <= cmd.priority_req;
					idx_q    <= '0;
					fprio_q  <= '0;
					rank_q   <= '0;
					status_q <= STAT_OK;
					if (cmd.opcode == OP_ADD) begin
						if (full) begin
							status_q <= STAT_FULL;
						end else if (bad_prio) begin
							status_q <= STAT_BAD_PRIORITY;
						end
					end
				end
			end
			ST_SCAN_RD: begin
				if (idx_q >= count_q && op_q != OP_ADD) begin
					status_q <= STAT_NOT_FOUND;
				end
			end
			ST_SCAN_CMP: begin
				if (key_hit) begin
					if (op_q == OP_ADD) begin
						status_q <= STAT_DUPLICATE;
					end else if (op_q == OP_FIND) begin
						fprio_q <= rd_entry.prio;
						rank_q  <= RANK_W'(idx_q);
					end
				end else begin
					idx_q <= idx_inc;
				end
			end
			ST_APPEND:  idx_q <= '0;
			ST_EX_LOAD: begin
				cur_q <= rd_entry;
				jdx_q <= idx_inc;
			end
			ST_EX_J_CMP: begin
				if (prio_lt) begin
					cur_q <= rd_entry;
				end
				jdx_q <= jdx_inc;
			end
			ST_EX_WB: idx_q <= idx_inc;
			ST_SH_WR: idx_q <= idx_inc;
			default: ;
		endcase
	end

	// writes stay inside the live part of the table, append writes the next free slot
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_req.we && state_q != ST_APPEND) |-> (CNT_W'(ram_req.waddr) < count_q))
		else $error("entry write beyond live entries");

	a_append_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND) |-> (CNT_W'(ram_req.waddr) == count_q && !full))
		else $error("append not at end of table");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == ST_APPEND || $past(state_q) == ST_SH_RD))
		else $error("entry count changed outside append or delete");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> (state_q == ST_IDLE && !busy))
		else $error("sequencer did not return to idle after result");

endmodule

### rtl/priority_sorted_keyed_table.sv
// priority_sorted_keyed_table: eight entry (key, priority) table kept in
// descending priority order, with add, find and delete by 64-bit key.
// Each command is one transaction: it is taken at a rising edge where start is
// high and busy is low, and busy stays high until the sequencer finishes. The
// result then shows on result with done high for exactly one cycle; the
// receiver cannot stall it, and busy is already low in that cycle so the next
// command may be taken at the same edge. Timing is set by the entry ram, which
// has one read and one write port with registered read, and by the sequencer
// that drives it: a lookup reads and compares each entry it passes in turn, a
// delete moves each later entry down one slot, and a successful add appends
// and then runs the exchange pass over the entries held. The shortest
// transactions are opcode three and an add into a full table or with a bad
// priority; the longest is an add into a table holding seven entries. The
// entry ram is not cleared; only entries below the count are ever used.
// depends on pstk_pkg, pstk_ram, pstk_ctrl
module priority_sorted_keyed_table (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  pstk_pkg::pstk_cmd_t    cmd,
	output logic                   done,
	output pstk_pkg::pstk_result_t result
);
	import pstk_pkg::*;

	pstk_ram_req_t  ram_req;
	pstk_entry_t    rd_entry;
	logic [ENTRY_W-1:0] rd_raw;
	pstk_rsp_t      rsp;

	// result register: one strobe cycle per transaction
	logic           done_q;
	pstk_result_t   result_q;

	// sequencer with the shared key and priority compare
	pstk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.ram_req  (ram_req),
		.rd_entry (rd_entry),
		.rsp      (rsp)
	);

	// entry storage, key and priority side by side
	pstk_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rd_raw)
	);

	assign rd_entry = rd_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rsp.done;
		end
	end

	// payload needs no reset, it is only looked at under done
	always_ff @(posedge clk) begin
		if (rsp.done) begin
			result_q <= rsp.res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
